[design/ctrp_pkg.sv]
// package with constants and tables for the csv trade record parser
`timescale 1ns / 1ps

package ctrp_pkg;

  typedef logic [63:0] word_t;

  localparam int FRAC_DIGITS = 8;

  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_POINT  = 8'h2E;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_ONE    = 8'h31;
  localparam logic [7:0] CHAR_UPPER_T = 8'h54;
  localparam logic [7:0] CHAR_LOWER_T = 8'h74;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam logic [2:0] FIELD_ID    = 3'd0;
  localparam logic [2:0] FIELD_PRICE = 3'd1;
  localparam logic [2:0] FIELD_QTY   = 3'd2;
  localparam logic [2:0] FIELD_QUOTE = 3'd3;
  localparam logic [2:0] FIELD_TIME  = 3'd4;
  localparam logic [2:0] FIELD_FLAG  = 3'd5;
  localparam logic [2:0] FIELD_SKIP  = 3'd6;

  localparam word_t LIMIT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam word_t LIMIT_NEG = 64'h8000_0000_0000_0000;

  localparam word_t POW10 [16] = '{
    64'd1,
    64'd10,
    64'd100,
    64'd1000,
    64'd10000,
    64'd100000,
    64'd1000000,
    64'd10000000,
    64'd100000000,
    64'd1000000000,
    64'd10000000000,
    64'd100000000000,
    64'd1000000000000,
    64'd10000000000000,
    64'd100000000000000,
    64'd1000000000000000
  };

  // weight of a digit before the point in a decimal field
  localparam word_t SCALE = POW10[FRAC_DIGITS];

endpackage

[design/csv_trade_record_parser.sv]
// top level of the csv trade record parser
//
// Takes one character of a comma separated trade line per item on the input
// channel (item_valid, item_stall, input_byte, last_byte) and gives a
// record per line that reaches the flag field on the output channel
// (record_valid, record_stall and the parsed fields). Decimals come out as
// fixed point with ctrp_pkg::FRAC_DIGITS fraction digits, with digits held
// pre-scaled so no rescale is needed at the end of a field.
// A byte is caught in an input register and is parsed once the output is
// free, where the per-byte shift-add and limit compare sit in front of the
// result register, which is loaded when the byte that ends a record is
// parsed. Throughput is one byte per cycle while the output is taken.
// While the receiver stalls a waiting record, one more byte is taken into
// the input register, then item_stall rises until the record leaves.
// Reset clears the valid flags of both registers and puts the parser at the
// first field of a fresh record. last_byte also returns the parser to that
// state after its record, if any, is formed.
`timescale 1ns / 1ps

module csv_trade_record_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [7:0]         input_byte,
  input  logic               last_byte,
  output logic               record_valid,
  input  logic               record_stall,
  output logic signed [63:0] trade_id,
  output logic signed [63:0] price_fixed,
  output logic signed [63:0] quantity_fixed,
  output logic signed [63:0] quote_quantity_fixed,
  output logic signed [63:0] time_ms,
  output logic               buyer_is_maker,
  output logic               is_buy,
  output logic               overflow,
  output logic [15:0]        line_bytes
);

  // input register
  logic       pend_valid;
  logic [7:0] pend_byte;
  logic       pend_last;

  // parser state
  logic [2:0]  field_position;
  logic [63:0] digit_accumulator;
  logic        negative_mark;
  logic        point_seen;
  logic [3:0]  fraction_count;
  logic        at_field_start;
  logic [63:0] id_hold, price_hold, quantity_hold, quote_hold, time_hold;
  logic        maker_hold;
  logic        overflow_hold;
  logic [15:0] byte_count;

  logic [2:0]  field_position_next;
  logic [63:0] digit_accumulator_next;
  logic        negative_mark_next;
  logic        point_seen_next;
  logic [3:0]  fraction_count_next;
  logic        at_field_start_next;
  logic [63:0] id_hold_next, price_hold_next, quantity_hold_next;
  logic [63:0] quote_hold_next, time_hold_next;
  logic        maker_hold_next;
  logic        overflow_hold_next;
  logic [15:0] byte_count_next;

  logic        out_free;
  logic        step;
  logic        emit;
  logic        clear;
  logic        is_digit;
  logic        is_decimal;
  logic        fraction_room;
  logic [3:0]  pow_index;
  logic [63:0] limit;
  logic [63:0] weight;
  logic [67:0] base;
  logic [67:0] term;
  logic [67:0] sum;
  logic [63:0] field_value;

  assign out_free   = !record_valid || !record_stall;
  assign step       = pend_valid && out_free;
  assign item_stall = pend_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      pend_valid <= 1'b1;
    end else if (step) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      pend_byte <= input_byte;
      pend_last <= last_byte;
    end
  end

  // digit arithmetic
  assign is_digit      = (pend_byte >= ctrp_pkg::CHAR_ZERO) && (pend_byte <= ctrp_pkg::CHAR_NINE);
  assign is_decimal    = field_position inside {[ctrp_pkg::FIELD_PRICE:ctrp_pkg::FIELD_QUOTE]};
  assign fraction_room = fraction_count < 4'(ctrp_pkg::FRAC_DIGITS);
  assign pow_index     = 4'(ctrp_pkg::FRAC_DIGITS - 1) - fraction_count;
  assign limit         = negative_mark ? ctrp_pkg::LIMIT_NEG : ctrp_pkg::LIMIT_POS;

  always_comb begin
    if (point_seen) begin
      weight = ctrp_pkg::POW10[pow_index];
    end else if (is_decimal) begin
      weight = ctrp_pkg::SCALE;
    end else begin
      weight = 64'd1;
    end
  end

  assign base = point_seen ? {4'b0000, digit_accumulator}
                           : 68'({digit_accumulator, 3'b000}) + 68'({digit_accumulator, 1'b0});
  assign term = 68'(weight) * 68'(pend_byte[3:0]);
  assign sum  = base + term;

  assign field_value = negative_mark ? (64'd0 - digit_accumulator) : digit_accumulator;

  always_comb begin
    field_position_next    = field_position;
    digit_accumulator_next = digit_accumulator;
    negative_mark_next     = negative_mark;
    point_seen_next        = point_seen;
    fraction_count_next    = fraction_count;
    at_field_start_next    = at_field_start;
    id_hold_next           = id_hold;
    price_hold_next        = price_hold;
    quantity_hold_next     = quantity_hold;
    quote_hold_next        = quote_hold;
    time_hold_next         = time_hold;
    maker_hold_next        = maker_hold;
    overflow_hold_next     = overflow_hold;
    emit                   = 1'b0;
    byte_count_next        = (byte_count == 16'hFFFF) ? byte_count : byte_count + 16'd1;

    if (field_position <= ctrp_pkg::FIELD_TIME) begin
      if (at_field_start && pend_byte == ctrp_pkg::CHAR_MINUS) begin
        negative_mark_next  = 1'b1;
        at_field_start_next = 1'b0;
      end else if (is_digit) begin
        at_field_start_next = 1'b0;
        if (!point_seen || fraction_room) begin
          if (sum > {4'b0000, limit}) begin
            digit_accumulator_next = limit;
            overflow_hold_next     = 1'b1;
          end else begin
            digit_accumulator_next = sum[63:0];
          end
          if (point_seen) begin
            fraction_count_next = fraction_count + 4'd1;
          end
        end
      end else if (pend_byte == ctrp_pkg::CHAR_POINT && is_decimal && !point_seen) begin
        point_seen_next     = 1'b1;
        at_field_start_next = 1'b0;
      end else begin
        case (field_position)
          ctrp_pkg::FIELD_ID:    id_hold_next       = field_value;
          ctrp_pkg::FIELD_PRICE: price_hold_next    = field_value;
          ctrp_pkg::FIELD_QTY:   quantity_hold_next = field_value;
          ctrp_pkg::FIELD_QUOTE: quote_hold_next    = field_value;
          default:               time_hold_next     = field_value;
        endcase
        field_position_next    = field_position + 3'd1;
        digit_accumulator_next = 64'd0;
        negative_mark_next     = 1'b0;
        point_seen_next        = 1'b0;
        fraction_count_next    = 4'd0;
        at_field_start_next    = 1'b1;
      end
    end else if (field_position == ctrp_pkg::FIELD_FLAG) begin
      maker_hold_next = (pend_byte == ctrp_pkg::CHAR_LOWER_T) ||
                        (pend_byte == ctrp_pkg::CHAR_UPPER_T) ||
                        (pend_byte == ctrp_pkg::CHAR_ONE);
      if (pend_byte == ctrp_pkg::CHAR_NEWLINE) begin
        emit = 1'b1;
      end else begin
        field_position_next = ctrp_pkg::FIELD_SKIP;
      end
    end else if (pend_byte == ctrp_pkg::CHAR_NEWLINE) begin
      emit = 1'b1;
    end

    // end of input at or past the flag field still gives a record
    if (!emit && pend_last && field_position_next >= ctrp_pkg::FIELD_FLAG) begin
      emit = 1'b1;
    end
  end

  assign clear = emit || pend_last;

  always_ff @(posedge clk) begin
    if (rst || (step && clear)) begin
      field_position    <= ctrp_pkg::FIELD_ID;
      digit_accumulator <= 64'd0;
      negative_mark     <= 1'b0;
      point_seen        <= 1'b0;
      fraction_count    <= 4'd0;
      at_field_start    <= 1'b1;
      id_hold           <= 64'd0;
      price_hold        <= 64'd0;
      quantity_hold     <= 64'd0;
      quote_hold        <= 64'd0;
      time_hold         <= 64'd0;
      maker_hold        <= 1'b0;
      overflow_hold     <= 1'b0;
      byte_count        <= 16'd0;
    end else if (step) begin
      field_position    <= field_position_next;
      digit_accumulator <= digit_accumulator_next;
      negative_mark     <= negative_mark_next;
      point_seen        <= point_seen_next;
      fraction_count    <= fraction_count_next;
      at_field_start    <= at_field_start_next;
      id_hold           <= id_hold_next;
      price_hold        <= price_hold_next;
      quantity_hold     <= quantity_hold_next;
      quote_hold        <= quote_hold_next;
      time_hold         <= time_hold_next;
      maker_hold        <= maker_hold_next;
      overflow_hold     <= overflow_hold_next;
      byte_count        <= byte_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      record_valid <= 1'b0;
    end else if (out_free) begin
      record_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && emit) begin
      trade_id             <= $signed(id_hold_next);
      price_fixed          <= $signed(price_hold_next);
      quantity_fixed       <= $signed(quantity_hold_next);
      quote_quantity_fixed <= $signed(quote_hold_next);
      time_ms              <= $signed(time_hold_next);
      buyer_is_maker       <= maker_hold_next;
      is_buy               <= !maker_hold_next;
      overflow             <= overflow_hold_next;
      line_bytes           <= byte_count_next;
    end
  end

endmodule

[tb/sv/tb_csv_trade_record_parser.sv]
// self-checking testbench for the csv trade record parser
`timescale 1ns / 1ps

module tb_csv_trade_record_parser;

  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_TILDE   = 8'h7E;
  localparam int         ITEM_TARGET  = 750;

  typedef struct {
    logic signed [63:0] id;
    logic signed [63:0] price;
    logic signed [63:0] qty;
    logic signed [63:0] quote;
    logic signed [63:0] tms;
    logic               maker;
    logic               buy;
    logic               ovf;
    logic [15:0]        nbytes;
  } trade_rec_t;

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_stall;
  logic [7:0]         input_byte;
  logic               last_byte;
  logic               record_valid;
  logic               record_stall;
  logic signed [63:0] trade_id;
  logic signed [63:0] price_fixed;
  logic signed [63:0] quantity_fixed;
  logic signed [63:0] quote_quantity_fixed;
  logic signed [63:0] time_ms;
  logic               buyer_is_maker;
  logic               is_buy;
  logic               overflow;
  logic [15:0]        line_bytes;

  csv_trade_record_parser DUT (
    .clk                  (clk),
    .rst                  (rst),
    .item_valid           (item_valid),
    .item_stall           (item_stall),
    .input_byte           (input_byte),
    .last_byte            (last_byte),
    .record_valid         (record_valid),
    .record_stall         (record_stall),
    .trade_id             (trade_id),
    .price_fixed          (price_fixed),
    .quantity_fixed       (quantity_fixed),
    .quote_quantity_fixed (quote_quantity_fixed),
    .time_ms              (time_ms),
    .buyer_is_maker       (buyer_is_maker),
    .is_buy               (is_buy),
    .overflow             (overflow),
    .line_bytes           (line_bytes)
  );

  trade_rec_t expected_records[$];
  logic [7:0] line_buf[$];
  int         mismatch_count = 0;
  int         items_sent = 0;
  bit         calm = 1'b0;

  // parser state mirrored by the predictor
  logic [2:0]      fld;
  ctrp_pkg::word_t mag;
  logic            neg;
  logic            pt;
  logic            fresh;
  int unsigned     nfrac;
  ctrp_pkg::word_t held [5];
  logic            maker_seen;
  logic            sat_seen;
  logic [15:0]     nbytes;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic ctrp_pkg::word_t mag_cap();
    return neg ? ctrp_pkg::LIMIT_NEG : ctrp_pkg::LIMIT_POS;
  endfunction

  function automatic void clear_field();
    mag   = '0;
    neg   = 1'b0;
    pt    = 1'b0;
    nfrac = 0;
    fresh = 1'b1;
  endfunction

  function automatic void clear_line();
    fld = ctrp_pkg::FIELD_ID;
    clear_field();
    foreach (held[i]) held[i] = '0;
    maker_seen = 1'b0;
    sat_seen   = 1'b0;
    nbytes     = '0;
  endfunction

  function automatic void add_digit(ctrp_pkg::word_t d);
    ctrp_pkg::word_t cap;
    cap = mag_cap();
    if (mag > (cap - d) / 64'd10) begin
      mag = cap;
      sat_seen = 1'b1;
    end else begin
      mag = mag * 64'd10 + d;
    end
  endfunction

  function automatic void close_field();
    ctrp_pkg::word_t cap;
    ctrp_pkg::word_t v;
    if (fld >= ctrp_pkg::FIELD_PRICE && fld <= ctrp_pkg::FIELD_QUOTE) begin
      cap = mag_cap();
      for (int k = nfrac; k < ctrp_pkg::FRAC_DIGITS; k++) begin
        if (mag > cap / 64'd10) begin
          mag = cap;
          sat_seen = 1'b1;
        end else begin
          mag = mag * 64'd10;
        end
      end
    end
    v = neg ? (64'd0 - mag) : mag;
    if (fld <= ctrp_pkg::FIELD_QUOTE) held[fld] = v;
    else held[ctrp_pkg::FIELD_TIME] = v;
  endfunction

  function automatic void parse_trade_byte(logic [7:0] b, logic l);
    logic       fire;
    trade_rec_t r;
    fire = 1'b0;
    if (nbytes != 16'hFFFF) nbytes++;
    if (fld <= ctrp_pkg::FIELD_TIME) begin
      if (fresh && b == ctrp_pkg::CHAR_MINUS) begin
        neg = 1'b1;
        fresh = 1'b0;
      end else if (b >= ctrp_pkg::CHAR_ZERO && b <= ctrp_pkg::CHAR_NINE) begin
        fresh = 1'b0;
        if (!pt) begin
          add_digit(ctrp_pkg::word_t'(b - ctrp_pkg::CHAR_ZERO));
        end else if (nfrac < ctrp_pkg::FRAC_DIGITS) begin
          add_digit(ctrp_pkg::word_t'(b - ctrp_pkg::CHAR_ZERO));
          nfrac++;
        end
      end else if (b == ctrp_pkg::CHAR_POINT && !pt &&
                   fld >= ctrp_pkg::FIELD_PRICE && fld <= ctrp_pkg::FIELD_QUOTE) begin
        pt = 1'b1;
        fresh = 1'b0;
      end else begin
        close_field();
        fld++;
        clear_field();
      end
    end else if (fld == ctrp_pkg::FIELD_FLAG) begin
      maker_seen = (b == ctrp_pkg::CHAR_LOWER_T || b == ctrp_pkg::CHAR_UPPER_T ||
                    b == ctrp_pkg::CHAR_ONE);
      if (b == ctrp_pkg::CHAR_NEWLINE) fire = 1'b1;
      else fld = ctrp_pkg::FIELD_SKIP;
    end else if (b == ctrp_pkg::CHAR_NEWLINE) begin
      fire = 1'b1;
    end
    if (!fire && l && fld >= ctrp_pkg::FIELD_FLAG) fire = 1'b1;
    if (fire) begin
      r.id     = held[ctrp_pkg::FIELD_ID];
      r.price  = held[ctrp_pkg::FIELD_PRICE];
      r.qty    = held[ctrp_pkg::FIELD_QTY];
      r.quote  = held[ctrp_pkg::FIELD_QUOTE];
      r.tms    = held[ctrp_pkg::FIELD_TIME];
      r.maker  = maker_seen;
      r.buy    = ~maker_seen;
      r.ovf    = sat_seen;
      r.nbytes = nbytes;
      expected_records.insert(expected_records.size(), r);
    end
    if (fire || l) clear_line();
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    trade_rec_t want;
    if (!rst && record_valid && !record_stall) begin
      if (expected_records.size() == 0) begin
        report_mismatch("record with none expected");
      end else begin
        want = expected_records.pop_front();
        check_field("trade_id", trade_id, want.id);
        check_field("price_fixed", price_fixed, want.price);
        check_field("quantity_fixed", quantity_fixed, want.qty);
        check_field("quote_quantity_fixed", quote_quantity_fixed, want.quote);
        check_field("time_ms", time_ms, want.tms);
        check_field("buyer_is_maker", 64'(buyer_is_maker), 64'(want.maker));
        check_field("is_buy", 64'(is_buy), 64'(want.buy));
        check_field("overflow", 64'(overflow), 64'(want.ovf));
        check_field("line_bytes", 64'(line_bytes), 64'(want.nbytes));
      end
    end
  end

  // receiver stalls
  initial begin
    int run;
    int hold;
    record_stall = 1'b0;
    forever begin
      run = $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      hold = idle_length();
      if (hold > 0) begin
        record_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        record_stall <= 1'b0;
      end
    end
  end

  function automatic void add_byte(logic [7:0] b);
    line_buf.insert(line_buf.size(), b);
  endfunction

  task automatic send_byte(logic [7:0] b, logic l);
    int gap;
    gap = idle_length();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    input_byte <= b;
    last_byte  <= l;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    parse_trade_byte(b, l);
  endtask

  task automatic send_buffer(bit ends_input);
    foreach (line_buf[i]) send_byte(line_buf[i], ends_input && i == line_buf.size() - 1);
  endtask

  // a tilde in the text stands for a zero byte
  task automatic send_text(string s, bit ends_input);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) add_byte(s[i] == CHAR_TILDE ? CHAR_NUL : s[i]);
    send_buffer(ends_input);
  endtask

  task automatic drain_records();
    item_valid <= 1'b0;
    @(posedge clk);
    while (expected_records.size() != 0) @(posedge clk);
  endtask

  function automatic void append_digits(int n);
    repeat (n) add_byte(8'(ctrp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
  endfunction

  function automatic void append_number(bit decimal);
    int r;
    int n;
    r = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) add_byte(ctrp_pkg::CHAR_MINUS);
    if (r == 0) n = 0;
    else if (r < 3) n = $urandom_range(18, 22);
    else if (decimal && r < 5) n = $urandom_range(10, 12);
    else n = $urandom_range(1, 7);
    append_digits(n);
    if (decimal && $urandom_range(0, 3) != 0) begin
      add_byte(ctrp_pkg::CHAR_POINT);
      append_digits($urandom_range(0, 11));
      if ($urandom_range(0, 24) == 0) begin
        add_byte(ctrp_pkg::CHAR_POINT);
        append_digits(1);
      end
    end else if (!decimal && $urandom_range(0, 29) == 0) begin
      add_byte(ctrp_pkg::CHAR_POINT);
      append_digits(2);
    end
  endfunction

  function automatic void append_separator();
    logic [7:0] b;
    if ($urandom_range(0, 9) != 0) begin
      b = CHAR_COMMA;
    end else begin
      do b = 8'($urandom);
      while ((b >= ctrp_pkg::CHAR_ZERO && b <= ctrp_pkg::CHAR_NINE) ||
             b == ctrp_pkg::CHAR_POINT || b == ctrp_pkg::CHAR_MINUS);
    end
    add_byte(b);
  endfunction

  function automatic void build_line();
    logic [7:0] f;
    logic [7:0] k;
    line_buf.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 30)) add_byte(8'($urandom));
      add_byte(ctrp_pkg::CHAR_NEWLINE);
      return;
    end
    append_number(1'b0);
    append_separator();
    repeat (3) begin
      append_number(1'b1);
      append_separator();
    end
    append_number(1'b0);
    append_separator();
    case ($urandom_range(0, 7))
      0: f = ctrp_pkg::CHAR_LOWER_T;
      1: f = ctrp_pkg::CHAR_UPPER_T;
      2: f = ctrp_pkg::CHAR_ONE;
      3: f = CHAR_LOWER_F;
      4: f = ctrp_pkg::CHAR_ZERO;
      5: f = ctrp_pkg::CHAR_NEWLINE;
      default: f = 8'($urandom);
    endcase
    add_byte(f);
    if (f != ctrp_pkg::CHAR_NEWLINE) begin
      repeat ($urandom_range(0, 6)) begin
        do k = 8'($urandom);
        while (k == ctrp_pkg::CHAR_NEWLINE);
        add_byte(k);
      end
      add_byte(ctrp_pkg::CHAR_NEWLINE);
    end
  endfunction

  task automatic test_basic_records();
    send_text("1,2.5,3,4,5,t\n", 1'b0);
    send_text("-12,-0.00000001,100.12345678,7.,-9,T\n", 1'b0);
    send_text("0,0,0,0,0,1\n", 1'b0);
    send_text("5,1.1,2.2,3.3,6,f\n", 1'b0);
  endtask

  task automatic test_sign_and_empty();
    send_text("-,-0,,.,-.,x\n", 1'b0);
    send_text("7-3,1.2.3,4,5,6,t\n", 1'b0);
    send_text("1.5,2,3,4,5.5,t\n", 1'b0);
  endtask

  task automatic test_saturation();
    send_text({"9223372036854775807,92233720368.54775807,-92233720368.54775808,",
               "92233720368.5477580799,-9223372036854775808,t\n"}, 1'b0);
    send_text({"9223372036854775808,92233720368.54775808,-92233720368.54775809,",
               "99999999999,-99999999999999999999,1\n"}, 1'b0);
    send_text("123456789012345678901234,0.123456789012,-0.999999999,100000000000,1,0\n", 1'b0);
  endtask

  task automatic test_separators();
    send_text("1;2|3\t4 5~t\n", 1'b0);
    send_text("1,2,3,4\n5,t\n", 1'b0);
    send_text("1,2,3,4,5,\n", 1'b0);
    send_text("1,2,3,4,5,Tabc,1.5\n", 1'b0);
  endtask

  task automatic test_end_of_input();
    send_text("1,2,3,4,5,t", 1'b1);
    send_text("1,2,3,4,5,", 1'b1);
    send_text("8,9,1.5,3,4", 1'b1);
    send_text("2,3,4,5,6,T\n", 1'b1);
    send_text("7", 1'b1);
    send_text("1,1,1,1,1,1\n", 1'b0);
  endtask

  task automatic test_drain_pause();
    send_text("3,4.25,5,6,7,1\n", 1'b0);
    send_text("-3,-4.25,-5,-6,-7,0\n", 1'b0);
    drain_records();
    send_text("9,8,7,6,5,t\n", 1'b0);
  endtask

  task automatic test_random_lines();
    int lines;
    int cut;
    lines = 0;
    while (items_sent < ITEM_TARGET) begin
      if (lines % 8 == 0) calm = ($urandom_range(0, 3) == 0);
      build_line();
      if ($urandom_range(0, 14) == 0) begin
        cut = $urandom_range(0, line_buf.size() - 1);
        line_buf = line_buf[0:cut];
        send_buffer(1'b1);
      end else begin
        send_buffer(1'b0);
      end
      lines++;
      if ($urandom_range(0, 19) == 0) drain_records();
    end
    calm = 1'b0;
  endtask

  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    input_byte = '0;
    last_byte  = 1'b0;
    clear_line();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_basic_records();
    test_sign_and_empty();
    test_saturation();
    test_separators();
    test_end_of_input();
    test_drain_pause();
    test_random_lines();
    drain_records();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
